@@ sv/sapm_pkg.sv @@
// Package for the servo angle to PWM mapper: shared types, codes and reset constants.
// Used by sapm_ctrl, sapm_dp and servo_angle_to_pwm_mapper; no dependencies.
package sapm_pkg;
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int SLOPE_W = 24;
    localparam int DIV_STEPS = 36;
    localparam logic [SLOPE_W-1:0] SLOPE_RESET = 24'd485451;
    localparam logic [15:0] RANGE_RESET = 16'd4320;

    localparam logic [2:0] REG_SERVO_COUNT = 3'd0;
    localparam logic [2:0] REG_MIN_US = 3'd1;
    localparam logic [2:0] REG_MAX_US = 3'd2;
    localparam logic [2:0] REG_MIN_TICK = 3'd3;
    localparam logic [2:0] REG_MAX_TICK = 3'd4;
    localparam logic [2:0] REG_COEFF = 3'd5;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD_SERVO = 2'd1;
    localparam logic [1:0] ST_TICK_RANGE = 2'd2;
    localparam logic [1:0] ST_ZERO_RANGE = 2'd3;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic write_entry;
        logic angle_stage;
        logic mul_us;
        logic mul_tick;
        logic finish_cmd;
    } cmd_t;

    typedef struct packed {
        logic invalid;
        logic is_write;
        logic zero_range;
        logic div_done;
    } stat_t;
endpackage

@@ sv/sapm_ctrl.sv @@
// Controller state machine of the servo mapper: sequences the datapath per transfer.
// Depends on sapm_pkg.
module sapm_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  sapm_pkg::stat_t  st,
    output sapm_pkg::cmd_t   cmd
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_DEC   = 8'b00000010,
        S_DIV   = 8'b00000100,
        S_WR    = 8'b00001000,
        S_ANG   = 8'b00010000,
        S_MUL1  = 8'b00100000,
        S_MUL2  = 8'b01000000,
        S_FIN   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    cmd.load = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                if (st.invalid || (st.is_write && st.zero_range)) begin
                    state_next = S_FIN;
                end else if (st.is_write) begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end else begin
                    state_next = S_ANG;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (st.div_done) state_next = S_WR;
            end
            S_WR: begin
                cmd.write_entry = 1'b1;
                state_next = S_FIN;
            end
            S_ANG: begin
                cmd.angle_stage = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1: begin
                cmd.mul_us = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul_tick = 1'b1;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    cmd.finish_cmd = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_one_hot: assert property (@(posedge aclk) disable iff (!aresetn) $onehot(state_reg))
        else $error("state not one-hot");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !in_ready) else $error("accept while busy");
    a_result_after_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && out_free) |=> out_valid_reg) else $error("result lost");
endmodule

@@ sv/sapm_dp.sv @@
// Datapath of the servo mapper: servo table, serial slope divider, clamp and multiplies.
// Depends on sapm_pkg; driven by sapm_ctrl.
module sapm_dp #(
    parameter int TABLE_DEPTH = sapm_pkg::TABLE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sapm_pkg::cmd_t        cmd,
    output sapm_pkg::stat_t       st,
    input  logic [92:0]           in_data,
    input  logic                  in_cmd,
    input  logic                  out_ready,
    input  logic                  out_valid,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_idx,
    input  logic [19:0]           cfg_data,
    output logic [39:0]           out_data
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [6:0]  servo_count_reg;
    logic [15:0] min_us_reg, max_us_reg;
    logic [11:0] min_tick_reg, max_tick_reg;
    logic [19:0] coeff_reg;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic signed [15:0] lo_mem [TABLE_DEPTH];
    logic signed [15:0] hi_mem [TABLE_DEPTH];
    logic signed [15:0] zo_mem [TABLE_DEPTH];
    logic [15:0] rng_mem [TABLE_DEPTH];
    logic [sapm_pkg::SLOPE_W-1:0] slope_mem [TABLE_DEPTH];
    logic inv_mem [TABLE_DEPTH];
    logic [3:0] ch_mem [TABLE_DEPTH];

    logic        is_wr_reg;
    logic [7:0]  idx_reg;
    logic signed [15:0] ang_reg, lo_in_reg, hi_in_reg, zo_in_reg;
    logic [15:0] rng_in_reg;
    logic        inv_in_reg;
    logic [3:0]  ch_in_reg;

    logic [IW-1:0] ix;
    assign ix = idx_reg[IW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            is_wr_reg  <= in_cmd;
            idx_reg    <= in_data[7:0];
            ang_reg    <= in_data[23:8];
            lo_in_reg  <= in_data[39:24];
            hi_in_reg  <= in_data[55:40];
            zo_in_reg  <= in_data[71:56];
            rng_in_reg <= in_data[87:72];
            inv_in_reg <= in_data[88];
            ch_in_reg  <= in_data[92:89];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            servo_count_reg <= 7'd16;
            min_us_reg <= 16'd500;
            max_us_reg <= 16'd2500;
            min_tick_reg <= 12'd0;
            max_tick_reg <= 12'd4095;
            coeff_reg <= 20'd13422;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                sapm_pkg::REG_SERVO_COUNT: servo_count_reg <= cfg_data[6:0];
                sapm_pkg::REG_MIN_US:      min_us_reg <= cfg_data[15:0];
                sapm_pkg::REG_MAX_US:      max_us_reg <= cfg_data[15:0];
                sapm_pkg::REG_MIN_TICK:    min_tick_reg <= cfg_data[11:0];
                sapm_pkg::REG_MAX_TICK:    max_tick_reg <= cfg_data[11:0];
                sapm_pkg::REG_COEFF:       coeff_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign st.invalid = ({1'b0, idx_reg} >= {2'b0, servo_count_reg})
                        || ({24'd0, idx_reg} >= TABLE_DEPTH[31:0]);
    assign st.is_write = is_wr_reg;
    assign st.zero_range = (rng_in_reg == 16'd0);

    // serial restoring divider: (diff << 20) / range
    logic [35:0] quo_reg;
    logic [16:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        crossed_reg;
    logic [16:0] rem_sh;
    assign rem_sh = {rem_reg[15:0], quo_reg[35]};
    assign st.div_done = (cnt_reg == 6'd1);

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            quo_reg <= {max_us_reg - min_us_reg, 20'd0};
            crossed_reg <= max_us_reg < min_us_reg;
            rem_reg <= '0;
            cnt_reg <= 6'(sapm_pkg::DIV_STEPS);
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg - 6'd1;
            if (rem_sh >= {1'b0, rng_in_reg}) begin
                rem_reg <= rem_sh - {1'b0, rng_in_reg};
                quo_reg <= {quo_reg[34:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[34:0], 1'b0};
            end
        end
    end

    logic [sapm_pkg::SLOPE_W-1:0] slope_new;
    assign slope_new = crossed_reg ? '0 : (|quo_reg[35:24]) ? '1 : quo_reg[23:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= '0;
        else if (cmd.write_entry) valid_reg[ix] <= 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_entry) begin
            lo_mem[ix] <= lo_in_reg;
            hi_mem[ix] <= hi_in_reg;
            zo_mem[ix] <= zo_in_reg;
            rng_mem[ix] <= rng_in_reg;
            slope_mem[ix] <= slope_new;
            inv_mem[ix] <= inv_in_reg;
            ch_mem[ix] <= ch_in_reg;
        end
    end

    logic signed [15:0] e_lo_reg, e_hi_reg, e_zo_reg;
    logic [15:0] e_rng_reg;
    logic [sapm_pkg::SLOPE_W-1:0] e_slope_reg;
    logic e_inv_reg;
    logic [3:0] e_ch_reg;
    always_ff @(posedge aclk) begin
        if (valid_reg[ix]) begin
            e_lo_reg <= lo_mem[ix]; e_hi_reg <= hi_mem[ix]; e_zo_reg <= zo_mem[ix];
            e_rng_reg <= rng_mem[ix]; e_slope_reg <= slope_mem[ix];
            e_inv_reg <= inv_mem[ix]; e_ch_reg <= ch_mem[ix];
        end else begin
            e_lo_reg <= '0; e_hi_reg <= '0; e_zo_reg <= '0;
            e_rng_reg <= sapm_pkg::RANGE_RESET; e_slope_reg <= sapm_pkg::SLOPE_RESET;
            e_inv_reg <= 1'b0; e_ch_reg <= 4'(ix);
        end
    end

    logic signed [16:0] a_neg, a_cl;
    logic signed [17:0] adj_reg;
    logic [sapm_pkg::SLOPE_W-1:0] slope_reg;
    logic [3:0] ch_reg;
    always_comb begin
        a_neg = e_inv_reg ? -17'(ang_reg) : 17'(ang_reg);
        a_cl = (a_neg < 17'(e_lo_reg)) ? 17'(e_lo_reg) : a_neg;
        if (a_cl > 17'(e_hi_reg)) a_cl = 17'(e_hi_reg);
    end

    logic signed [42:0] sum_reg;
    logic [15:0] us;
    logic [35:0] tk_reg;
    always_ff @(posedge aclk) begin
        if (cmd.angle_stage) begin
            adj_reg <= 18'(a_cl) + 18'({1'b0, e_rng_reg[15:1]}) + 18'(e_zo_reg);
            slope_reg <= e_slope_reg;
            ch_reg <= e_ch_reg;
        end
        if (cmd.mul_us)
            sum_reg <= 43'($signed({1'b0, min_us_reg, 20'd0}))
                     + 43'($signed({1'b0, slope_reg}) * adj_reg);
        if (cmd.mul_tick) tk_reg <= us * coeff_reg;
    end

    assign us = sum_reg[42] ? 16'd0 : (|sum_reg[41:36]) ? 16'hFFFF : sum_reg[35:20];

    logic [15:0] ticks;
    assign ticks = (|tk_reg[35:32]) ? 16'hFFFF : tk_reg[31:16];

    logic [1:0] tick_st;
    assign tick_st = (ticks > {4'd0, max_tick_reg} || ticks < {4'd0, min_tick_reg})
                     ? sapm_pkg::ST_TICK_RANGE : sapm_pkg::ST_OK;

    logic [39:0] res_reg;
    always_ff @(posedge aclk) begin
        if (cmd.finish_cmd) begin
            if (st.invalid) res_reg <= {38'd0, sapm_pkg::ST_BAD_SERVO};
            else if (is_wr_reg && st.zero_range)
                res_reg <= {38'd0, sapm_pkg::ST_ZERO_RANGE};
            else if (is_wr_reg) res_reg <= {34'd0, ch_in_reg, sapm_pkg::ST_OK};
            else res_reg <= {adj_reg, ticks, ch_reg, tick_st};
        end
    end

    assign out_data = res_reg;

    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> (cnt_reg == 6'(sapm_pkg::DIV_STEPS))) else $error("divider start");
    a_write_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_entry |-> (!st.invalid && !st.zero_range)) else $error("bad table write");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> $stable(res_reg)) else $error("result changed");
endmodule

@@ sv/servo_angle_to_pwm_mapper.sv @@
// Top level of the servo angle to PWM mapper: stream ports and config write port.
// Depends on sapm_pkg, sapm_ctrl and sapm_dp.
// Per transfer: an angle command reads the table, clamps and does two multiplies; a
// settings write runs the serial slope divider and writes the table entry; an invalid
// index or zero range goes straight to the result. One item in flight; a stalled
// result holds the next item in its final state.
// Reset: aresetn synchronous active low restores registers and marks all table
// entries at their reset values at once; no clearing pass.
module servo_angle_to_pwm_mapper #(
    parameter int TABLE_DEPTH = sapm_pkg::TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,  // servo_index, angle, lower_limit, upper_limit,
                                  // zero_offset, travel_range, invert_flag, channel
    input  logic        s_tuser,  // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // status, out_channel, tick_count, adjusted_angle
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [19:0] cfg_data
);
    sapm_pkg::cmd_t  cmd;
    sapm_pkg::stat_t st;

    sapm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .st(st), .cmd(cmd)
    );

    sapm_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .st(st), .in_data(s_tdata[92:0]),
        .in_cmd(s_tuser), .out_valid(m_tvalid), .out_ready(m_tready),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data), .out_data(m_tdata)
    );
endmodule

@@ tb/tb.sv @@
// Testbench for servo_angle_to_pwm_mapper: drives command and settings-write transfers
// with random gaps and stalls, and checks every result against a built-in predictor.
// Depends on sapm_pkg and the servo_angle_to_pwm_mapper RTL.
`timescale 1ns / 1ps

module tb;
    localparam int NSERVO = 16;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  servo_index;
        logic [15:0] angle;
        logic [15:0] lower_limit;
        logic [15:0] upper_limit;
        logic [15:0] zero_offset;
        logic [15:0] travel_range;
        logic        invert_flag;
        logic [3:0]  channel;
    } servo_item_t;

    localparam int ITEM_W = $bits(servo_item_t);

    typedef struct packed {
        logic [17:0] adjusted_angle;
        logic [15:0] tick_count;
        logic [3:0]  out_channel;
        logic [1:0]  status;
    } pwm_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [19:0] cfg_data = '0;

    servo_angle_to_pwm_mapper dut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    int unsigned     p_count, p_min_us, p_max_us, p_min_tk, p_max_tk, p_coeff;
    int              p_lower[NSERVO], p_upper[NSERVO], p_offset[NSERVO];
    int unsigned     p_range[NSERVO], p_slope[NSERVO];
    bit              p_inv[NSERVO];
    logic [3:0]      p_chan[NSERVO];

    servo_item_t     pending_items[$];
    pwm_result_t     expected_results[$];
    int              errors = 0;
    int              send_gap = 0, recv_gap = 0;
    bit              in_fire = 1'b0, out_fire = 1'b0;

    function automatic int unsigned slope_for(int unsigned rng);
        longint unsigned q;
        if (rng == 0 || p_max_us < p_min_us) return 0;
        q = (longint'(p_max_us - p_min_us) << 20) / rng;
        return q > 64'hFFFFFF ? 32'hFFFFFF : 32'(q);
    endfunction

    function automatic void predictor_reset();
        p_count = 16; p_min_us = 500; p_max_us = 2500;
        p_min_tk = 0; p_max_tk = 4095; p_coeff = 13422;
        for (int i = 0; i < NSERVO; i++) begin
            p_lower[i] = 0; p_upper[i] = 0; p_offset[i] = 0;
            p_range[i] = 4320; p_slope[i] = slope_for(4320);
            p_inv[i] = 0; p_chan[i] = i[3:0];
        end
    endfunction

    function automatic logic [95:0] pack_item(servo_item_t it);
        return {3'd0, it.channel, it.invert_flag, it.travel_range, it.zero_offset,
                it.upper_limit, it.lower_limit, it.angle, it.servo_index};
    endfunction

    function automatic pwm_result_t map_angle(servo_item_t it);
        pwm_result_t r;
        int unsigned idx;
        longint a, adj, sum;
        longint unsigned us, tk;
        r = '0;
        idx = it.servo_index;
        if (idx >= p_count || idx >= NSERVO) begin
            r.status = sapm_pkg::ST_BAD_SERVO;
        end else if (it.cmd) begin
            if (it.travel_range == 0) begin
                r.status = sapm_pkg::ST_ZERO_RANGE;
            end else begin
                p_lower[idx] = $signed(it.lower_limit);
                p_upper[idx] = $signed(it.upper_limit);
                p_offset[idx] = $signed(it.zero_offset);
                p_range[idx] = it.travel_range;
                p_slope[idx] = slope_for(it.travel_range);
                p_inv[idx] = it.invert_flag;
                p_chan[idx] = it.channel;
                r.status = sapm_pkg::ST_OK;
                r.out_channel = it.channel;
            end
        end else begin
            a = $signed(it.angle);
            if (p_inv[idx]) a = -a;
            if (a < p_lower[idx]) a = p_lower[idx];
            if (a > p_upper[idx]) a = p_upper[idx];
            adj = a + longint'(p_range[idx] >> 1) + p_offset[idx];
            sum = longint'(p_min_us) * 1048576 + longint'(p_slope[idx]) * adj;
            if (sum < 0) us = 0;
            else begin
                us = longint'(sum) >> 20;
                if (us > 65535) us = 65535;
            end
            tk = (us * p_coeff) >> 16;
            if (tk > 65535) tk = 65535;
            r.tick_count = tk[15:0];
            r.out_channel = p_chan[idx];
            r.adjusted_angle = adj[17:0];
            r.status = (tk > p_max_tk || tk < p_min_tk) ? sapm_pkg::ST_TICK_RANGE
                                                        : sapm_pkg::ST_OK;
        end
        return r;
    endfunction

    // driver
    always @(negedge aclk) begin
        int g;
        if (aresetn) begin
            if (!s_tvalid || in_fire) begin
                if (send_gap > 0 || pending_items.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (send_gap > 0) send_gap <= send_gap - 1;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tuser <= pending_items[0].cmd;
                    s_tdata <= pack_item(pending_items[0]);
                    pending_items.pop_front();
                    send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
                end
            end
            if (out_fire) begin
                g = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 11));
                m_tready <= (g == 0);
                recv_gap <= (g > 0) ? g - 1 : 0;
            end else if (recv_gap > 0) begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // accept input transfers and predict
    always @(posedge aclk) begin
        servo_item_t it;
        in_fire = aresetn && s_tvalid && s_tready;
        if (in_fire) begin
            it.cmd = s_tuser;
            it.servo_index = s_tdata[7:0];
            it.angle = s_tdata[23:8];
            it.lower_limit = s_tdata[39:24];
            it.upper_limit = s_tdata[55:40];
            it.zero_offset = s_tdata[71:56];
            it.travel_range = s_tdata[87:72];
            it.invert_flag = s_tdata[88];
            it.channel = s_tdata[92:89];
            expected_results.push_back(map_angle(it));
        end
    end

    // monitor
    always @(posedge aclk) begin
        pwm_result_t got, want;
        out_fire = aresetn && m_tvalid && m_tready;
        if (out_fire) begin
            got = m_tdata;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                if (got.out_channel !== want.out_channel)
                    $display("%0t: channel exp %0d got %0d", $time,
                             want.out_channel, got.out_channel);
                if (got.tick_count !== want.tick_count)
                    $display("%0t: ticks exp %0d got %0d", $time,
                             want.tick_count, got.tick_count);
                if (got.adjusted_angle !== want.adjusted_angle)
                    $display("%0t: angle exp %h got %h", $time,
                             want.adjusted_angle, got.adjusted_angle);
                if (got !== want) errors++;
            end
        end
    end

    function automatic servo_item_t rand_item(bit well_formed);
        servo_item_t it;
        it = ITEM_W'({$urandom, $urandom, $urandom});
        if (well_formed) begin
            it.servo_index = 8'($urandom_range(0, p_count > 0 ? p_count : 1));
            if (it.cmd) begin
                it.lower_limit = $urandom_range(0, 3) ? 16'($signed($urandom_range(0, 3000)) - 3000)
                                                      : it.lower_limit;
                it.upper_limit = $urandom_range(0, 3) ? 16'($urandom_range(0, 3000))
                                                      : it.upper_limit;
                it.zero_offset = $urandom_range(0, 1) ? 16'($signed($urandom_range(0, 400)) - 200)
                                                      : it.zero_offset;
                if ($urandom_range(0, 15) == 0) it.travel_range = 16'd0;
                else if ($urandom_range(0, 1)) it.travel_range = 16'($urandom_range(1, 6000));
            end else if ($urandom_range(0, 1)) begin
                it.angle = 16'($signed($urandom_range(0, 6000)) - 3000);
            end
        end
        return it;
    endfunction

    task automatic drain();
        while (!(pending_items.size() == 0 && !s_tvalid && expected_results.size() == 0))
            @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [19:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            sapm_pkg::REG_SERVO_COUNT: p_count = val[6:0];
            sapm_pkg::REG_MIN_US:      p_min_us = val[15:0];
            sapm_pkg::REG_MAX_US:      p_max_us = val[15:0];
            sapm_pkg::REG_MIN_TICK:    p_min_tk = val[11:0];
            sapm_pkg::REG_MAX_TICK:    p_max_tk = val[11:0];
            sapm_pkg::REG_COEFF:       p_coeff = val;
            default: ;
        endcase
    endtask

    initial begin
        servo_item_t it;
        predictor_reset();
        repeat (5) @(posedge aclk);
        @(negedge aclk) aresetn = 1'b1;

        // directed
        it = '0;
        for (int i = 0; i < 4; i++) begin
            it.cmd = 0; it.servo_index = 8'(i); it.angle = 16'(16'h7FFF - i * 16'h7FFF);
            pending_items.push_back(it);
        end
        it = '0; it.servo_index = 8'hFF; pending_items.push_back(it);
        it.servo_index = 8'd16; pending_items.push_back(it);
        it = '0; it.cmd = 1; it.servo_index = 8'd2; it.travel_range = 16'd0;
        pending_items.push_back(it);
        it = '0; it.cmd = 1; it.servo_index = 8'd3; it.lower_limit = 16'h8000;
        it.upper_limit = 16'h7FFF; it.zero_offset = 16'h7FFF; it.travel_range = 16'hFFFF;
        it.invert_flag = 1; it.channel = 4'hF; pending_items.push_back(it);
        it = '0; it.servo_index = 8'd3; it.angle = 16'h8000; pending_items.push_back(it);
        it.angle = 16'h7FFF; pending_items.push_back(it);
        it = '0; it.cmd = 1; it.servo_index = 8'd5; it.lower_limit = 16'd100;
        it.upper_limit = 16'hFF00; it.zero_offset = 16'h8000; it.travel_range = 16'd1;
        it.channel = 4'h9; pending_items.push_back(it);
        it = '0; it.servo_index = 8'd5; it.angle = 16'd50; pending_items.push_back(it);
        it = '0; it.cmd = 1; it.servo_index = 8'd15; it.lower_limit = 16'hF000;
        it.upper_limit = 16'h1000; it.travel_range = 16'd2880; pending_items.push_back(it);
        it = '0; it.servo_index = 8'd15; it.angle = 16'hFFF0; pending_items.push_back(it);
        drain();

        // every register, extremes and stale slopes
        write_reg(sapm_pkg::REG_MIN_US, 20'd0);
        write_reg(sapm_pkg::REG_MAX_US, 20'hFFFF);
        write_reg(sapm_pkg::REG_COEFF, 20'hFFFFF);
        write_reg(sapm_pkg::REG_MIN_TICK, 20'd100);
        write_reg(sapm_pkg::REG_MAX_TICK, 20'd3000);
        write_reg(sapm_pkg::REG_SERVO_COUNT, 20'd0);
        write_reg(3'd7, 20'd5);
        it = '0; pending_items.push_back(it);
        drain();
        write_reg(sapm_pkg::REG_SERVO_COUNT, 20'd127);

        for (int ph = 0; ph < 6; ph++) begin
            for (int k = 0; k < 320; k++)
                pending_items.push_back(rand_item($urandom_range(0, 9) != 0));
            if (ph == 2) begin
                drain();
            end else begin
                wait (pending_items.size() == 0);
            end
            drain();
            case (ph)
                0: begin
                    write_reg(sapm_pkg::REG_MIN_US, 20'd1500);
                    write_reg(sapm_pkg::REG_MAX_US, 20'd800);
                    write_reg(sapm_pkg::REG_COEFF, 20'd0);
                    write_reg(sapm_pkg::REG_MIN_TICK, 20'd0);
                    write_reg(sapm_pkg::REG_SERVO_COUNT, 20'd1);
                end
                1: begin
                    write_reg(sapm_pkg::REG_COEFF, 20'($urandom_range(0, 20'hFFFFF)));
                    write_reg(sapm_pkg::REG_MIN_US, 20'($urandom_range(0, 3000)));
                    write_reg(sapm_pkg::REG_MAX_US, 20'($urandom_range(0, 20000)));
                    write_reg(sapm_pkg::REG_SERVO_COUNT, 20'd16);
                    write_reg(sapm_pkg::REG_MAX_TICK, 20'hFFF);
                end
                2: begin
                    write_reg(sapm_pkg::REG_SERVO_COUNT, 20'd9);
                    write_reg(sapm_pkg::REG_MIN_TICK, 20'hFFF);
                    write_reg(sapm_pkg::REG_MAX_TICK, 20'd0);
                end
                3: begin
                    write_reg(sapm_pkg::REG_SERVO_COUNT, 20'd64);
                    write_reg(sapm_pkg::REG_MIN_TICK, 20'd200);
                    write_reg(sapm_pkg::REG_MAX_TICK, 20'd3500);
                    write_reg(sapm_pkg::REG_COEFF, 20'd13422);
                    write_reg(sapm_pkg::REG_MIN_US, 20'd500);
                    write_reg(sapm_pkg::REG_MAX_US, 20'd2500);
                end
                default: write_reg(sapm_pkg::REG_COEFF, 20'($urandom_range(0, 20'hFFFFF)));
            endcase
        end
        drain();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule
